FILE: hw/rtl/dbcf_pkg.sv
package dbcf_pkg;

    // Field widths
    localparam int DEPTH_W    = 15;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int CMD_W      = 16;
    localparam int COUNT_W    = 19;
    localparam int SUM_W      = 40;
    localparam int COORD_W    = 26;
    localparam int MEAN_W     = 33;
    localparam int STATUS_W   = 2;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults
    localparam int CENTER_COL_DEF    = 320;
    localparam int CENTER_ROW_DEF    = 240;
    localparam int MIN_POINTS_DEF    = 100;
    localparam int INV_FOCAL_Q24_DEF = 29137;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_UP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_UP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_DEPTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_DEPTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN  = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_BOX_MIN_X     = 16'hFCCD;
    localparam logic [15:0] RST_BOX_MAX_X     = 16'd819;
    localparam logic [15:0] RST_BOX_MIN_UP    = 16'd410;
    localparam logic [15:0] RST_BOX_MAX_UP    = 16'd2048;
    localparam logic [14:0] RST_BOX_MAX_DEPTH = 15'd3277;
    localparam logic [14:0] RST_GOAL_DEPTH    = 15'd2458;
    localparam logic [15:0] RST_LINEAR_GAIN   = 16'd4096;
    localparam logic [15:0] RST_ANGULAR_GAIN  = 16'd20480;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_FOLLOW = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FEW    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAR    = 2'd2;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [CMD_W-1:0] linear_cmd;
        logic signed [CMD_W-1:0] angular_cmd;
        logic signed [CMD_W-1:0] centroid_x;
        logic [DEPTH_W-1:0]      nearest_z;
        logic [COUNT_W-1:0]      point_total;
        logic [STATUS_W-1:0]     status;
    } t_out;

    typedef struct packed {
        logic signed [15:0]  box_min_x;
        logic signed [15:0]  box_max_x;
        logic signed [15:0]  box_min_up;
        logic signed [15:0]  box_max_up;
        logic [DEPTH_W-1:0]  box_max_depth;
        logic [DEPTH_W-1:0]  goal_depth;
        logic [GAIN_W-1:0]   linear_gain;
        logic [GAIN_W-1:0]   angular_gain;
    } t_cfg;

    // One classified pixel, passed from the front end to the accumulator.
    typedef struct packed {
        logic                      counted;
        logic signed [COORD_W-1:0] x;
        logic [DEPTH_W-1:0]        depth;
        logic                      last;
    } t_cls;

endpackage

FILE: hw/rtl/dbcf_front.sv
module dbcf_front #(
    parameter int CENTER_COL    = dbcf_pkg::CENTER_COL_DEF,
    parameter int CENTER_ROW    = dbcf_pkg::CENTER_ROW_DEF,
    parameter int INV_FOCAL_Q24 = dbcf_pkg::INV_FOCAL_Q24_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  dbcf_pkg::t_in    i_in_data,
    output logic             o_in_stall,
    input  dbcf_pkg::t_cfg   i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output dbcf_pkg::t_cls   o_item
);

    localparam logic [10:0] CCOL = 11'(CENTER_COL);
    localparam logic [10:0] CROW = 11'(CENTER_ROW);
    localparam logic [23:0] INV  = 24'(INV_FOCAL_Q24);

    logic en;
    logic [10:0] dcol;
    logic [10:0] drow;
    logic [10:0] dcol_neg;
    logic [10:0] drow_neg;
    logic [38:0] scale;
    logic [48:0] xprod;
    logic [48:0] uprod;

    // Stage 0: offsets from the image center
    logic                              r_v0, r_last0, r_cneg0, r_rneg0;
    logic [dbcf_pkg::DEPTH_W-1:0]      r_depth0;
    logic [9:0]                        r_cmag0, r_rmag0;
    // Stage 1: depth times reciprocal focal length
    logic                              r_v1, r_last1, r_cneg1, r_rneg1;
    logic [dbcf_pkg::DEPTH_W-1:0]      r_depth1;
    logic [9:0]                        r_cmag1, r_rmag1;
    logic [38:0]                       r_scale1;
    // Stage 2: lateral magnitude
    logic                              r_v2, r_last2, r_cneg2, r_rneg2;
    logic [dbcf_pkg::DEPTH_W-1:0]      r_depth2;
    logic [9:0]                        r_rmag2;
    logic [38:0]                       r_scale2;
    logic [24:0]                       r_xmag2;
    // Stage 3: vertical magnitude and signed lateral coordinate
    logic                              r_v3, r_last3, r_rneg3;
    logic [dbcf_pkg::DEPTH_W-1:0]      r_depth3;
    logic [24:0]                       r_umag3;
    logic signed [dbcf_pkg::COORD_W-1:0] r_x3;

    logic signed [dbcf_pkg::COORD_W-1:0] xs;
    logic signed [dbcf_pkg::COORD_W-1:0] ups;
    logic signed [dbcf_pkg::COORD_W-1:0] b_min_x, b_max_x, b_min_up, b_max_up;
    logic in_box;

    assign en         = !i_full;
    assign o_in_stall = i_full;

    assign dcol     = {1'b0, i_in_data.col} - CCOL;
    assign drow     = CROW - {2'b0, i_in_data.row};
    assign dcol_neg = -dcol;
    assign drow_neg = -drow;
    assign scale    = r_depth0 * INV;
    assign xprod    = r_cmag1 * r_scale1;
    assign uprod    = r_rmag2 * r_scale2;

    assign xs = r_cneg2 ? -$signed({1'b0, r_xmag2}) : $signed({1'b0, r_xmag2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_depth0 <= i_in_data.depth;
            r_last0  <= i_in_data.last;
            r_cneg0  <= dcol[10];
            r_cmag0  <= dcol[10] ? dcol_neg[9:0] : dcol[9:0];
            r_rneg0  <= drow[10];
            r_rmag0  <= drow[10] ? drow_neg[9:0] : drow[9:0];

            r_depth1 <= r_depth0;
            r_last1  <= r_last0;
            r_cneg1  <= r_cneg0;
            r_cmag1  <= r_cmag0;
            r_rneg1  <= r_rneg0;
            r_rmag1  <= r_rmag0;
            r_scale1 <= scale;

            r_depth2 <= r_depth1;
            r_last2  <= r_last1;
            r_cneg2  <= r_cneg1;
            r_rneg2  <= r_rneg1;
            r_rmag2  <= r_rmag1;
            r_scale2 <= r_scale1;
            r_xmag2  <= xprod[48:24];

            r_depth3 <= r_depth2;
            r_last3  <= r_last2;
            r_rneg3  <= r_rneg2;
            r_umag3  <= uprod[48:24];
            r_x3     <= xs;
        end
    end

    assign ups = r_rneg3 ? -$signed({1'b0, r_umag3}) : $signed({1'b0, r_umag3});

    assign b_min_x  = {{10{i_cfg.box_min_x[15]}},  i_cfg.box_min_x};
    assign b_max_x  = {{10{i_cfg.box_max_x[15]}},  i_cfg.box_max_x};
    assign b_min_up = {{10{i_cfg.box_min_up[15]}}, i_cfg.box_min_up};
    assign b_max_up = {{10{i_cfg.box_max_up[15]}}, i_cfg.box_max_up};

    // A zero depth is a missing reading and never counts.
    assign in_box = (r_depth3 != '0) && (ups > b_min_up) && (ups < b_max_up) &&
                    (r_x3 < b_max_x) && (r_x3 > b_min_x) &&
                    (r_depth3 < i_cfg.box_max_depth);

    always_comb begin
        o_item.counted = in_box;
        o_item.x       = r_x3;
        o_item.depth   = r_depth3;
        o_item.last    = r_last3;
    end

    assign o_push = r_v3 && en;

endmodule

FILE: hw/rtl/dbcf_queue.sv
module dbcf_queue #(
    parameter int DEPTH = dbcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dbcf_pkg::t_cls i_item,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output dbcf_pkg::t_cls o_item
);

    // DEPTH is a power of two; the pointers carry one extra wrap bit.
    localparam int AW = $clog2(DEPTH);

    dbcf_pkg::t_cls r_mem [DEPTH];
    logic [AW:0] r_wptr;
    logic [AW:0] r_rptr;

    assign o_valid = (r_wptr != r_rptr);
    assign o_full  = (r_wptr[AW] != r_rptr[AW]) && (r_wptr[AW-1:0] == r_rptr[AW-1:0]);
    assign o_item  = r_mem[r_rptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr[AW-1:0]] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/dbcf_div.sv
module dbcf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dbcf_pkg::SUM_W-1:0]    i_dividend,
    input  logic [dbcf_pkg::COUNT_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [dbcf_pkg::SUM_W-1:0]    o_quotient
);

    localparam int STEPS = dbcf_pkg::SUM_W;
    localparam int CW    = $clog2(STEPS);
    localparam int DW    = dbcf_pkg::COUNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [STEPS-1:0] r_work;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out of the top of r_work while quotient bits fill in from the bottom.
    assign rem_sh  = {r_rem, r_work[STEPS-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
            r_cnt  <= CW'(STEPS - 1);
        end else if (r_busy) begin
            r_work <= {r_work[STEPS-2:0], ge};
            r_rem  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

FILE: hw/rtl/dbcf_back.sv
module dbcf_back #(
    parameter int MIN_POINTS = dbcf_pkg::MIN_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  dbcf_pkg::t_cls i_q_item,
    output logic           o_pop,
    input  dbcf_pkg::t_cfg i_cfg,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dbcf_pkg::t_out o_out_data
);

    localparam int SW = dbcf_pkg::SUM_W;
    localparam int CW = dbcf_pkg::COUNT_W;
    localparam int DW = dbcf_pkg::DEPTH_W;
    localparam int MW = dbcf_pkg::MEAN_W;

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    function automatic logic [15:0] sat_mag(input logic neg, input logic [SW-1:0] mag);
        logic [15:0] val;
        begin
            if (!neg) begin
                val = (mag > SW'(32767)) ? 16'h7FFF : mag[15:0];
            end else begin
                val = (mag > SW'(32768)) ? 16'h8000 : -mag[15:0];
            end
            return val;
        end
    endfunction

    logic [2:0]    r_state, n_state;

    // Running accumulators of the open frame
    logic [SW-1:0] r_sum, n_sum;
    logic [DW-1:0] r_min, n_min;
    logic [CW-1:0] r_count, n_count;

    // Snapshot of the closed frame
    logic [SW-1:0] r_f_sum;
    logic [DW-1:0] r_f_min;
    logic [CW-1:0] r_f_count;
    logic          r_few;

    logic          r_dz_neg;
    logic [DW-1:0] r_dz_mag;
    logic [30:0]   r_lin_prod;
    logic [48:0]   r_ang_prod;

    logic          r_out_valid;
    dbcf_pkg::t_out r_out_data;

    logic          pop;
    logic          enough;
    logic          div_start;
    logic          div_done;
    logic [SW-1:0] quo;
    logic [SW-1:0] sum_mag;
    logic [DW:0]   dz;
    logic [DW:0]   dz_neg;
    logic [MW-1:0] q_clamp;
    logic          out_free;
    logic          load;
    dbcf_pkg::t_out res;

    assign pop   = i_q_valid && (r_state == ST_ACC);
    assign o_pop = pop;

    always_comb begin
        n_sum   = r_sum;
        n_min   = r_min;
        n_count = r_count;
        if (pop && i_q_item.counted && (r_count != '1)) begin
            n_sum   = r_sum + {{(SW - dbcf_pkg::COORD_W){i_q_item.x[dbcf_pkg::COORD_W-1]}},
                               i_q_item.x};
            n_min   = (i_q_item.depth < r_min) ? i_q_item.depth : r_min;
            n_count = r_count + 1'b1;
        end
    end

    assign enough = (n_count > CW'(MIN_POINTS));

    assign sum_mag   = r_f_sum[SW-1] ? -r_f_sum : r_f_sum;
    assign div_start = (r_state == ST_START);

    dbcf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (r_f_count),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign dz     = {1'b0, r_f_min} - {1'b0, i_cfg.goal_depth};
    assign dz_neg = -dz;

    // Above this bound the angular command saturates for any nonzero gain.
    assign q_clamp = (quo[SW-1:MW] != '0) ? '1 : quo[MW-1:0];

    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = (r_state == ST_FIN) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (pop && i_q_item.last) begin
                    n_state = enough ? ST_START : ST_FIN;
                end
            end
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_sum   <= '0;
            r_min   <= '1;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (pop && i_q_item.last) begin
                r_sum   <= '0;
                r_min   <= '1;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_min   <= n_min;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_item.last) begin
            r_f_sum   <= n_sum;
            r_f_min   <= n_min;
            r_f_count <= n_count;
            r_few     <= !enough;
        end
        if (r_state == ST_START) begin
            r_dz_neg <= dz[DW];
            r_dz_mag <= dz[DW] ? dz_neg[DW-1:0] : dz[DW-1:0];
        end
        if (r_state == ST_MUL) begin
            r_lin_prod <= r_dz_mag * i_cfg.linear_gain;
            r_ang_prod <= q_clamp * i_cfg.angular_gain;
        end
    end

    always_comb begin
        res.linear_cmd  = '0;
        res.angular_cmd = '0;
        res.centroid_x  = '0;
        res.nearest_z   = r_f_min;
        res.point_total = r_f_count;
        res.status      = dbcf_pkg::STATUS_FEW;
        if (!r_few) begin
            res.centroid_x = sat_mag(r_f_sum[SW-1], quo);
            if (r_f_min > i_cfg.box_max_depth) begin
                res.status = dbcf_pkg::STATUS_FAR;
            end else begin
                res.status      = dbcf_pkg::STATUS_FOLLOW;
                res.linear_cmd  = sat_mag(r_dz_neg, SW'(r_lin_prod[30:12]));
                // The turn command opposes the sign of the mean.
                res.angular_cmd = sat_mag(!r_f_sum[SW-1], SW'(r_ang_prod[48:12]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/depth_box_centroid_follower_unit.sv
// Depth window follower: one depth pixel (depth, column, row, last flag) is
// accepted per clock whenever o_in_stall is low. Each pixel is projected and
// box-tested in the front pipeline and then queued for the accumulator,
// which takes one queued pixel per cycle while accumulating. The pixel
// flagged last closes the frame; when more than MIN_POINTS pixels were
// counted, a bit-serial divider forms the mean lateral coordinate, so a
// frame with enough points holds the accumulator in its start, divide,
// multiply and finish states after its last pixel (only the finish state
// otherwise), longer while the previous result still waits on the output.
// During that time the queue fills and the input stalls. One result per
// frame appears on the output register and waits there, without blocking
// the next frame's pixels, until it is taken. Configuration writes are
// always ready and should be made only while no frame is in flight.
module depth_box_centroid_follower_unit #(
    parameter int CENTER_COL    = dbcf_pkg::CENTER_COL_DEF,
    parameter int CENTER_ROW    = dbcf_pkg::CENTER_ROW_DEF,
    parameter int MIN_POINTS    = dbcf_pkg::MIN_POINTS_DEF,
    parameter int INV_FOCAL_Q24 = dbcf_pkg::INV_FOCAL_Q24_DEF,
    parameter int QUEUE_DEPTH   = dbcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  dbcf_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output dbcf_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dbcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dbcf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    dbcf_pkg::t_cfg r_cfg;
    dbcf_pkg::t_cls front_item;
    dbcf_pkg::t_cls q_item;
    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_min_x     <= dbcf_pkg::RST_BOX_MIN_X;
            r_cfg.box_max_x     <= dbcf_pkg::RST_BOX_MAX_X;
            r_cfg.box_min_up    <= dbcf_pkg::RST_BOX_MIN_UP;
            r_cfg.box_max_up    <= dbcf_pkg::RST_BOX_MAX_UP;
            r_cfg.box_max_depth <= dbcf_pkg::RST_BOX_MAX_DEPTH;
            r_cfg.goal_depth    <= dbcf_pkg::RST_GOAL_DEPTH;
            r_cfg.linear_gain   <= dbcf_pkg::RST_LINEAR_GAIN;
            r_cfg.angular_gain  <= dbcf_pkg::RST_ANGULAR_GAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dbcf_pkg::REG_BOX_MIN_X:     r_cfg.box_min_x     <= i_cfg_data;
                dbcf_pkg::REG_BOX_MAX_X:     r_cfg.box_max_x     <= i_cfg_data;
                dbcf_pkg::REG_BOX_MIN_UP:    r_cfg.box_min_up    <= i_cfg_data;
                dbcf_pkg::REG_BOX_MAX_UP:    r_cfg.box_max_up    <= i_cfg_data;
                dbcf_pkg::REG_BOX_MAX_DEPTH: r_cfg.box_max_depth <=
                                                 i_cfg_data[dbcf_pkg::DEPTH_W-1:0];
                dbcf_pkg::REG_GOAL_DEPTH:    r_cfg.goal_depth    <=
                                                 i_cfg_data[dbcf_pkg::DEPTH_W-1:0];
                dbcf_pkg::REG_LINEAR_GAIN:   r_cfg.linear_gain   <= i_cfg_data;
                dbcf_pkg::REG_ANGULAR_GAIN:  r_cfg.angular_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dbcf_front #(
        .CENTER_COL    (CENTER_COL),
        .CENTER_ROW    (CENTER_ROW),
        .INV_FOCAL_Q24 (INV_FOCAL_Q24)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_full     (q_full),
        .o_push     (push),
        .o_item     (front_item)
    );

    dbcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    dbcf_back #(
        .MIN_POINTS (MIN_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF       = 2;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 100;
    localparam int PHASE_FRAMES   = 3;

    typedef enum {ROW_PIXELS, ROW_REG_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                          kind;
        int unsigned                        reps;
        dbcf_pkg::t_in                      px;
        logic [dbcf_pkg::CFG_IDX_W-1:0]     reg_idx;
        logic [dbcf_pkg::CFG_DATA_W-1:0]    reg_val;
        bit                                 typed;
        dbcf_pkg::t_out                     want;
    } t_plan_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    dbcf_pkg::t_in                      i_in_data = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    dbcf_pkg::t_out                     o_out_data;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [dbcf_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [dbcf_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    // Shadow copy of the registers and the frame accumulators.
    dbcf_pkg::t_cfg model_cfg = {dbcf_pkg::RST_BOX_MIN_X, dbcf_pkg::RST_BOX_MAX_X,
                                 dbcf_pkg::RST_BOX_MIN_UP, dbcf_pkg::RST_BOX_MAX_UP,
                                 dbcf_pkg::RST_BOX_MAX_DEPTH, dbcf_pkg::RST_GOAL_DEPTH,
                                 dbcf_pkg::RST_LINEAR_GAIN, dbcf_pkg::RST_ANGULAR_GAIN};
    logic [dbcf_pkg::SUM_W-1:0]   acc_sum_x = '0;
    logic [dbcf_pkg::DEPTH_W-1:0] acc_near_z = '1;
    logic [dbcf_pkg::COUNT_W-1:0] acc_points = '0;

    dbcf_pkg::t_out frame_results_due[$];
    t_plan_row      plan[$];
    int             err_count = 0;
    int             quiet_cycles = 0;
    int             in_idle_pct = 0;
    int             out_stall_pct = 0;

    depth_box_centroid_follower_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // (a * b) >> sh with the magnitude truncated, so the result rounds toward zero.
    function automatic longint mul_trunc_shr(longint a, longint b, int unsigned sh);
        longint mag;
        longint r;
        mag = (a < 0) ? -a : a;
        r = (mag * b) >> sh;
        return (a < 0) ? -r : r;
    endfunction

    function automatic logic signed [dbcf_pkg::CMD_W-1:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[dbcf_pkg::CMD_W-1:0];
    endfunction

    function automatic bit inside_box(dbcf_pkg::t_in px, output longint x);
        longint scale;
        longint up;
        scale = longint'(px.depth) * dbcf_pkg::INV_FOCAL_Q24_DEF;
        x = mul_trunc_shr(longint'(px.col) - dbcf_pkg::CENTER_COL_DEF, scale, 24);
        up = mul_trunc_shr(dbcf_pkg::CENTER_ROW_DEF - longint'(px.row), scale, 24);
        return up > longint'($signed(model_cfg.box_min_up)) &&
               up < longint'($signed(model_cfg.box_max_up)) &&
               x < longint'($signed(model_cfg.box_max_x)) &&
               x > longint'($signed(model_cfg.box_min_x)) &&
               px.depth < model_cfg.box_max_depth;
    endfunction

    task automatic track_pixel(input dbcf_pkg::t_in px, output bit fired,
                               output dbcf_pkg::t_out res);
        longint x;
        longint mean;
        fired = 1'b0;
        res = '0;
        if (px.depth != 0 && acc_points != '1 && inside_box(px, x)) begin
            acc_sum_x = acc_sum_x + dbcf_pkg::SUM_W'(x);
            if (px.depth < acc_near_z)
                acc_near_z = px.depth;
            acc_points = acc_points + 1'b1;
        end
        if (px.last) begin
            fired = 1'b1;
            res.nearest_z = acc_near_z;
            res.point_total = acc_points;
            res.status = dbcf_pkg::STATUS_FEW;
            if (acc_points > dbcf_pkg::MIN_POINTS_DEF) begin
                mean = longint'($signed(acc_sum_x)) / longint'(acc_points);
                res.centroid_x = clamp16(mean);
                if (acc_near_z > model_cfg.box_max_depth) begin
                    res.status = dbcf_pkg::STATUS_FAR;
                end else begin
                    res.linear_cmd = clamp16(mul_trunc_shr(longint'(acc_near_z) -
                        longint'(model_cfg.goal_depth), longint'(model_cfg.linear_gain), 12));
                    res.angular_cmd = clamp16(-mul_trunc_shr(mean,
                        longint'(model_cfg.angular_gain), 12));
                    res.status = dbcf_pkg::STATUS_FOLLOW;
                end
            end
            acc_sum_x = '0;
            acc_near_z = '1;
            acc_points = '0;
        end
    endtask

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    task automatic check_result(input dbcf_pkg::t_out got);
        dbcf_pkg::t_out want;
        if (frame_results_due.size() == 0) begin
            report_error($sformatf("result with none outstanding: %h", got));
        end else begin
            want = frame_results_due.pop_front();
            if (got.linear_cmd !== want.linear_cmd)
                report_error($sformatf("linear_cmd expected %0d, got %0d",
                    want.linear_cmd, got.linear_cmd));
            if (got.angular_cmd !== want.angular_cmd)
                report_error($sformatf("angular_cmd expected %0d, got %0d",
                    want.angular_cmd, got.angular_cmd));
            if (got.centroid_x !== want.centroid_x)
                report_error($sformatf("centroid_x expected %0d, got %0d",
                    want.centroid_x, got.centroid_x));
            if (got.nearest_z !== want.nearest_z)
                report_error($sformatf("nearest_z expected %0d, got %0d",
                    want.nearest_z, got.nearest_z));
            if (got.point_total !== want.point_total)
                report_error($sformatf("point_total expected %0d, got %0d",
                    want.point_total, got.point_total));
            if (got.status !== want.status)
                report_error($sformatf("status expected %0d, got %0d",
                    want.status, got.status));
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            check_result(o_out_data);
    end

    // Any accepted transaction on any channel resets the hang counter.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input dbcf_pkg::t_in px, input bit typed,
                              input dbcf_pkg::t_out want);
        bit             fired;
        dbcf_pkg::t_out predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= px;
        do
            @(posedge i_clk);
        while (o_in_stall);
        track_pixel(px, fired, predicted);
        if (fired)
            frame_results_due.push_back(typed ? want : predicted);
    endtask

    // Pixels that produce no result may still be in the pipeline once the
    // last result is out, so hold off a while before touching registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dbcf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbcf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dbcf_pkg::REG_BOX_MIN_X:     model_cfg.box_min_x = data;
            dbcf_pkg::REG_BOX_MAX_X:     model_cfg.box_max_x = data;
            dbcf_pkg::REG_BOX_MIN_UP:    model_cfg.box_min_up = data;
            dbcf_pkg::REG_BOX_MAX_UP:    model_cfg.box_max_up = data;
            dbcf_pkg::REG_BOX_MAX_DEPTH:
                model_cfg.box_max_depth = data[dbcf_pkg::DEPTH_W-1:0];
            dbcf_pkg::REG_GOAL_DEPTH:
                model_cfg.goal_depth = data[dbcf_pkg::DEPTH_W-1:0];
            dbcf_pkg::REG_LINEAR_GAIN:   model_cfg.linear_gain = data;
            dbcf_pkg::REG_ANGULAR_GAIN:  model_cfg.angular_gain = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [15:0] min_x, input logic [15:0] max_x,
                                 input logic [15:0] min_up, input logic [15:0] max_up,
                                 input logic [15:0] max_depth, input logic [15:0] goal,
                                 input logic [15:0] lin_gain, input logic [15:0] ang_gain);
        settle();
        write_reg(dbcf_pkg::REG_BOX_MIN_X, min_x);
        write_reg(dbcf_pkg::REG_BOX_MAX_X, max_x);
        write_reg(dbcf_pkg::REG_BOX_MIN_UP, min_up);
        write_reg(dbcf_pkg::REG_BOX_MAX_UP, max_up);
        write_reg(dbcf_pkg::REG_BOX_MAX_DEPTH, max_depth);
        write_reg(dbcf_pkg::REG_GOAL_DEPTH, goal);
        write_reg(dbcf_pkg::REG_LINEAR_GAIN, lin_gain);
        write_reg(dbcf_pkg::REG_ANGULAR_GAIN, ang_gain);
    endtask

    function automatic t_plan_row px_row(int unsigned reps, int depth, int col, int row,
                                         bit last, bit typed = 1'b0,
                                         dbcf_pkg::t_out want = '0);
        t_plan_row r;
        r = '{kind: ROW_PIXELS, default: '0};
        r.reps = reps;
        r.px.depth = depth[dbcf_pkg::DEPTH_W-1:0];
        r.px.col = col[dbcf_pkg::COL_W-1:0];
        r.px.row = row[dbcf_pkg::ROW_W-1:0];
        r.px.last = last;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_plan_row reg_row(logic [dbcf_pkg::CFG_IDX_W-1:0] idx,
                                          logic [dbcf_pkg::CFG_DATA_W-1:0] val);
        t_plan_row r;
        r = '{kind: ROW_REG_WRITE, default: '0};
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // A stopped frame: both commands and the centroid read zero.
    function automatic dbcf_pkg::t_out stop_result(int near, int total,
                                                   logic [dbcf_pkg::STATUS_W-1:0] status);
        dbcf_pkg::t_out r;
        r = '0;
        r.nearest_z = near[dbcf_pkg::DEPTH_W-1:0];
        r.point_total = total[dbcf_pkg::COUNT_W-1:0];
        r.status = status;
        return r;
    endfunction

    function automatic dbcf_pkg::t_in noise_pixel();
        dbcf_pkg::t_in px;
        px.depth = ($urandom_range(7) == 0) ? '0 :
                   dbcf_pkg::DEPTH_W'($urandom_range(32767, 1));
        px.col = dbcf_pkg::COL_W'($urandom_range(1023));
        px.row = dbcf_pkg::ROW_W'($urandom_range(511));
        px.last = 1'b0;
        return px;
    endfunction

    // Draws pixels until one lands in the current box, giving up after 16 tries.
    function automatic dbcf_pkg::t_in aimed_pixel();
        dbcf_pkg::t_in px;
        longint        unused_x;
        int unsigned   top;
        top = (model_cfg.box_max_depth > 1) ? model_cfg.box_max_depth - 1 : 32767;
        for (int t = 0; t < 16; t++) begin
            px.depth = dbcf_pkg::DEPTH_W'($urandom_range(top, 1));
            px.col = dbcf_pkg::COL_W'($urandom_range(639));
            px.row = dbcf_pkg::ROW_W'($urandom_range(479));
            px.last = 1'b0;
            if (inside_box(px, unused_x))
                break;
        end
        return px;
    endfunction

    // Occasional long frames mostly aimed at the box, mixed with more frequent short noisy ones.
    task automatic run_phase(input int in_pct, input int out_pct);
        int            items;
        int            frames;
        int unsigned   n;
        bit            follow;
        dbcf_pkg::t_in px;
        in_idle_pct = in_pct;
        out_stall_pct = out_pct;
        items = 0;
        frames = 0;
        while (items < PHASE_ITEMS || frames < PHASE_FRAMES) begin
            follow = ($urandom_range(99) < 25);
            n = follow ? $urandom_range(135, 101) : $urandom_range(12, 1);
            for (int unsigned k = 0; k < n; k++) begin
                px = (follow && $urandom_range(9) != 0) ? aimed_pixel() : noise_pixel();
                px.last = (k == n - 1);
                send_pixel(px, 1'b0, '0);
            end
            items += n;
            frames++;
        end
    endtask

    initial begin
        plan.push_back(px_row(1, 0, 0, 0, 1, 1'b1,
                              stop_result(32767, 0, dbcf_pkg::STATUS_FEW)));
        plan.push_back(px_row(1, 32767, 1023, 511, 1, 1'b1,
                              stop_result(32767, 0, dbcf_pkg::STATUS_FEW)));
        plan.push_back(px_row(1, 1, 0, 0, 0));
        plan.push_back(px_row(1, 2000, 320, 40, 1, 1'b1,
                              stop_result(2000, 1, dbcf_pkg::STATUS_FEW)));
        // One point short of enough, then exactly enough.
        plan.push_back(px_row(100, 2000, 400, 40, 0));
        plan.push_back(px_row(1, 0, 0, 0, 1, 1'b1,
                              stop_result(2000, 100, dbcf_pkg::STATUS_FEW)));
        plan.push_back(px_row(101, 2000, 400, 40, 0));
        plan.push_back(px_row(1, 0, 0, 0, 1));
        plan.push_back(reg_row(dbcf_pkg::REG_LINEAR_GAIN, 16'hFFFF));
        plan.push_back(reg_row(dbcf_pkg::REG_ANGULAR_GAIN, 16'hFFFF));
        plan.push_back(reg_row(dbcf_pkg::REG_GOAL_DEPTH, 16'h7FFF));
        plan.push_back(px_row(120, 1500, 100, 40, 0));
        plan.push_back(px_row(1, 1500, 100, 40, 1));
        // Nearest point ends up beyond a limit lowered in the middle of the frame.
        plan.push_back(reg_row(dbcf_pkg::REG_GOAL_DEPTH, 16'h0000));
        plan.push_back(px_row(110, 3000, 320, 40, 0));
        plan.push_back(reg_row(dbcf_pkg::REG_BOX_MAX_DEPTH, 16'd1000));
        plan.push_back(px_row(1, 0, 0, 0, 1, 1'b1,
                              stop_result(3000, 110, dbcf_pkg::STATUS_FAR)));
        plan.push_back(reg_row(dbcf_pkg::REG_BOX_MAX_DEPTH, 16'h0000));
        plan.push_back(px_row(1, 5, 320, 40, 1, 1'b1,
                              stop_result(32767, 0, dbcf_pkg::STATUS_FEW)));
        // Widest box; the top bit of the depth limit write is dropped by the register.
        plan.push_back(reg_row(dbcf_pkg::REG_BOX_MIN_X, 16'h8000));
        plan.push_back(reg_row(dbcf_pkg::REG_BOX_MAX_X, 16'h7FFF));
        plan.push_back(reg_row(dbcf_pkg::REG_BOX_MIN_UP, 16'h8000));
        plan.push_back(reg_row(dbcf_pkg::REG_BOX_MAX_UP, 16'h7FFF));
        plan.push_back(reg_row(dbcf_pkg::REG_BOX_MAX_DEPTH, 16'hFFFF));
        plan.push_back(px_row(1, 32766, 639, 0, 1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG_WRITE) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                for (int unsigned k = 0; k < plan[i].reps; k++)
                    send_pixel(plan[i].px, plan[i].typed, plan[i].want);
            end
        end

        apply_setting(dbcf_pkg::RST_BOX_MIN_X, dbcf_pkg::RST_BOX_MAX_X,
                      dbcf_pkg::RST_BOX_MIN_UP, dbcf_pkg::RST_BOX_MAX_UP,
                      16'(dbcf_pkg::RST_BOX_MAX_DEPTH), 16'(dbcf_pkg::RST_GOAL_DEPTH),
                      dbcf_pkg::RST_LINEAR_GAIN, dbcf_pkg::RST_ANGULAR_GAIN);
        run_phase(0, 0);
        apply_setting(-16'sd3000, 16'd3000, -16'sd1000, 16'd6000, 16'd12000, 16'd0,
                      16'hFFFF, 16'd1);
        run_phase(88, 0);
        apply_setting(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'd12345, 16'hFFFF);
        run_phase(0, 88);
        apply_setting(-16'sd200, 16'd200, 16'd0, 16'd1500, 16'd2000, 16'd1000,
                      16'd8192, 16'd0);
        run_phase(6, 6);

        settle();
        if (err_count == 0 && frame_results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dbcf_pkg.sv
hw/rtl/dbcf_front.sv
hw/rtl/dbcf_queue.sv
hw/rtl/dbcf_div.sv
hw/rtl/dbcf_back.sv
hw/rtl/depth_box_centroid_follower_unit.sv
verif/testbench.sv
